>>> sv/rcwt_pkg.sv
package rcwt_pkg;

    // Shared arithmetic unit: 32-bit operands, one bit per cycle.
    localparam int ALU_BITS = 32;
    localparam int ALU_CNT_W = 5;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic start;
        logic op;
    } alu_req_t;

    typedef struct packed {
        logic done;
    } alu_rsp_t;

endpackage

>>> sv/raycast_wall_column_texturer.sv
// Textured wall column generator for a grid raycaster. A load word (tuser 0)
// sets up a column: the wall height, the clipped row range, the mirrored
// texture column, and the Q16.16 texel step and start position. Each tick
// word (tuser 1) then yields one pixel, top to bottom, with tlast on the final
// row; ticks arriving with no column set up produce nothing. A single shared
// divide/multiply unit works one bit per cycle. A load keeps s_axis_tready
// low through the wall height division, the row range step, the texel step
// division, the start position multiplication and the step that opens the
// column. When the top of the wall lies inside the screen the start position
// is zero and the multiplication is skipped; a zero wall height skips both
// the texel step division and the multiplication. Ticks are taken one per
// cycle while the output register is free or being drained. A load never
// produces an output word.
module raycast_wall_column_texturer
#(
    parameter int SCREEN_HEIGHT = 480,
    parameter int TEX_W         = 64,
    parameter int TEX_H         = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column[9:0], distance[25:10], wall_frac[41:26], side[42],
    // dir_x_positive[43], dir_y_negative[44], texture_id[46:45]
    input  logic [rcwt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_column[9:0], row[18:10], out_texture[20:19], texel_index[32:21]
    output logic [rcwt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int NUM_H = SCREEN_HEIGHT * 256;
    localparam int HW    = $clog2(NUM_H + 1);
    localparam int MID   = SCREEN_HEIGHT / 2;
    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int TCW   = $clog2(TEX_W);
    localparam int TRW   = $clog2(TEX_H);
    localparam int NUM_S = TEX_H * 65536;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_H = 3'd1;
    localparam logic [2:0] S_GEOM  = 3'd2;
    localparam logic [2:0] S_DIV_S = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic           active_reg, active_next;
    logic [9:0]     cur_column_reg, cur_column_next;
    logic [1:0]     cur_texture_reg, cur_texture_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [RW-1:0]  end_row_reg, end_row_next;
    logic [TCW-1:0] tex_column_reg, tex_column_next;
    logic [31:0]    tex_pos_reg, tex_pos_next;
    logic [31:0]    tex_step_reg, tex_step_next;
    logic [HW-1:0]  h_reg, h_next;
    logic           half_ge_reg, half_ge_next;

    logic           out_valid_reg, out_valid_next;
    logic [9:0]     out_column_reg, out_column_next;
    logic [8:0]     out_row_reg, out_row_next;
    logic [1:0]     out_texture_reg, out_texture_next;
    logic [11:0]    out_texel_reg, out_texel_next;
    logic           out_last_reg, out_last_next;

    rcwt_pkg::alu_req_t alu_req;
    rcwt_pkg::alu_rsp_t alu_rsp;
    logic [31:0]        alu_a;
    logic [31:0]        alu_b;
    logic [31:0]        alu_result;

    logic [9:0]     in_column;
    logic [15:0]    in_distance;
    logic [15:0]    in_frac;
    logic           in_side;
    logic           in_xpos;
    logic           in_yneg;
    logic [1:0]     in_texture;
    logic           accept;

    logic [31:0]    frac_scaled;
    logic [TCW-1:0] tx_raw;
    logic [TCW-1:0] tx;

    logic [HW-1:0]  half;
    logic           half_ge;
    logic [HW-1:0]  mid_minus_half;
    logic [HW:0]    mid_plus_half;
    logic [RW-1:0]  start_row;
    logic [RW-1:0]  stop_row;
    logic [31:0]    pos_mult;

    logic [15:0]    pos_hi;
    logic [TRW-1:0] tex_row;
    logic [31:0]    texel_full;
    logic [31:0]    row_full;
    logic           last_pixel;

    rcwt_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign in_column   = s_axis_tdata[9:0];
    assign in_distance = s_axis_tdata[25:10];
    assign in_frac     = s_axis_tdata[41:26];
    assign in_side     = s_axis_tdata[42];
    assign in_xpos     = s_axis_tdata[43];
    assign in_yneg     = s_axis_tdata[44];
    assign in_texture  = s_axis_tdata[46:45];

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Texture column from the hit fraction, mirrored for the back faces.
    always_comb
    begin
        frac_scaled = 32'(in_frac) * 32'(TEX_W);
        tx_raw      = frac_scaled[16 +: TCW];
        if ((!in_side && in_xpos) || (in_side && in_yneg))
        begin
            tx = TCW'(TEX_W - 1) - tx_raw;
        end
        else
        begin
            tx = tx_raw;
        end
    end

    // Row range from the wall height.
    always_comb
    begin
        half           = h_reg >> 1;
        half_ge        = (half >= HW'(MID));
        mid_minus_half = HW'(MID) - half;
        mid_plus_half  = {1'b0, half} + (HW + 1)'(MID);
        start_row      = half_ge ? '0 : mid_minus_half[RW-1:0];
        if (mid_plus_half >= (HW + 1)'(SCREEN_HEIGHT - 1))
        begin
            stop_row = RW'(SCREEN_HEIGHT - 1);
        end
        else
        begin
            stop_row = mid_plus_half[RW-1:0];
        end
        pos_mult = 32'(half - HW'(MID));
    end

    // Pixel of the current tick.
    always_comb
    begin
        pos_hi = tex_pos_reg[31:16];
        if (pos_hi > 16'(TEX_H - 1))
        begin
            tex_row = TRW'(TEX_H - 1);
        end
        else
        begin
            tex_row = pos_hi[TRW-1:0];
        end
        texel_full = 32'(tex_row) * 32'(TEX_H) + 32'(tex_column_reg);
        row_full   = 32'(cur_row_reg);
        last_pixel = ({1'b0, cur_row_reg} + 1'b1) >= {1'b0, end_row_reg};
    end

    always_comb
    begin
        state_next       = state_reg;
        active_next      = active_reg;
        cur_column_next  = cur_column_reg;
        cur_texture_next = cur_texture_reg;
        cur_row_next     = cur_row_reg;
        end_row_next     = end_row_reg;
        tex_column_next  = tex_column_reg;
        tex_pos_next     = tex_pos_reg;
        tex_step_next    = tex_step_reg;
        h_next           = h_reg;
        half_ge_next     = half_ge_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_column_next  = out_column_reg;
        out_row_next     = out_row_reg;
        out_texture_next = out_texture_reg;
        out_texel_next   = out_texel_reg;
        out_last_next    = out_last_reg;
        alu_req.start    = 1'b0;
        alu_req.op       = rcwt_pkg::OP_DIV;
        alu_a            = 32'(NUM_H);
        alu_b            = 32'(in_distance);

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_axis_tuser == rcwt_pkg::REQ_LOAD))
                begin
                    // A zero distance divides by one, which gives the
                    // saturated height directly.
                    active_next      = 1'b0;
                    cur_column_next  = in_column;
                    cur_texture_next = in_texture;
                    tex_column_next  = tx;
                    alu_req.start    = 1'b1;
                    alu_req.op       = rcwt_pkg::OP_DIV;
                    alu_a            = 32'(NUM_H);
                    alu_b            = (in_distance == 16'd0) ? 32'd1 : 32'(in_distance);
                    state_next       = S_DIV_H;
                end
                else if (accept && active_reg)
                begin
                    out_valid_next   = 1'b1;
                    out_column_next  = cur_column_reg;
                    out_row_next     = row_full[8:0];
                    out_texture_next = cur_texture_reg;
                    out_texel_next   = texel_full[11:0];
                    out_last_next    = last_pixel;
                    tex_pos_next     = tex_pos_reg + tex_step_reg;
                    cur_row_next     = cur_row_reg + 1'b1;
                    if (last_pixel)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            S_DIV_H:
            begin
                if (alu_rsp.done)
                begin
                    h_next     = alu_result[HW-1:0];
                    state_next = S_GEOM;
                end
            end
            S_GEOM:
            begin
                cur_row_next = start_row;
                end_row_next = stop_row;
                half_ge_next = half_ge;
                if (h_reg == '0)
                begin
                    tex_step_next = '0;
                    tex_pos_next  = '0;
                    state_next    = S_FIN;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = rcwt_pkg::OP_DIV;
                    alu_a         = 32'(NUM_S);
                    alu_b         = 32'(h_reg);
                    state_next    = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                if (alu_rsp.done)
                begin
                    tex_step_next = alu_result;
                    if (half_ge_reg)
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = rcwt_pkg::OP_MUL;
                        alu_a         = pos_mult;
                        alu_b         = alu_result;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        tex_pos_next = '0;
                        state_next   = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                if (alu_rsp.done)
                begin
                    tex_pos_next = alu_result;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                active_next = (cur_row_reg < end_row_reg);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_column_reg  <= cur_column_next;
        cur_texture_reg <= cur_texture_next;
        cur_row_reg     <= cur_row_next;
        end_row_reg     <= end_row_next;
        tex_column_reg  <= tex_column_next;
        tex_pos_reg     <= tex_pos_next;
        tex_step_reg    <= tex_step_next;
        h_reg           <= h_next;
        half_ge_reg     <= half_ge_next;
        out_column_reg  <= out_column_next;
        out_row_reg     <= out_row_next;
        out_texture_reg <= out_texture_next;
        out_texel_reg   <= out_texel_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_texel_reg, out_texture_reg, out_row_reg, out_column_reg};

    // A column is never live while the sequencer is still setting one up.
    a_idle_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !active_reg)
        else $error("column active during setup");

    // A live column always has at least one row left to emit.
    a_rows_left: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_row_reg < end_row_reg))
        else $error("active column with no rows left");

    // The shared unit only finishes while the sequencer waits on it.
    a_alu_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_DIV_H || state_reg == S_DIV_S
                          || state_reg == S_MUL))
        else $error("unexpected arithmetic completion");

    // The final pixel closes the column.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_axis_tuser == rcwt_pkg::REQ_TICK) && active_reg && last_pixel)
        |=> (!active_reg && m_axis_tvalid && m_axis_tlast))
        else $error("column not closed after final pixel");

endmodule

>>> sv/rcwt_alu.sv
module rcwt_alu
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rcwt_pkg::alu_req_t                  req,
    input  logic [rcwt_pkg::ALU_BITS-1:0]       a,
    input  logic [rcwt_pkg::ALU_BITS-1:0]       b,
    output rcwt_pkg::alu_rsp_t                  rsp,
    output logic [rcwt_pkg::ALU_BITS-1:0]       result
);

    localparam int N = rcwt_pkg::ALU_BITS;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         op_reg, op_next;
    logic [rcwt_pkg::ALU_CNT_W-1:0] cnt_reg, cnt_next;
    logic [N:0]                   acc_reg, acc_next;
    logic [N-1:0]                 x_reg, x_next;
    logic [N-1:0]                 y_reg, y_next;

    logic [N:0]   shifted;
    logic [N+1:0] lhs;
    logic [N+1:0] addend;
    logic [N+1:0] sum;
    logic         is_div;

    // One adder serves both operations: a trial subtract for restoring
    // division and an accumulate for shift-and-add multiplication.
    always_comb
    begin
        is_div  = (op_reg == rcwt_pkg::OP_DIV);
        shifted = {acc_reg[N-1:0], x_reg[N-1]};
        lhs     = is_div ? {1'b0, shifted} : {1'b0, acc_reg};
        addend  = is_div ? ~{2'b00, y_reg} : {2'b00, x_reg};
        sum     = lhs + addend + {{(N+1){1'b0}}, is_div};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            x_next    = a;
            y_next    = b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rcwt_pkg::ALU_CNT_W'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (is_div)
            begin
                if (!sum[N+1])
                begin
                    acc_next = sum[N:0];
                end
                else
                begin
                    acc_next = shifted;
                end
                x_next = {x_reg[N-2:0], ~sum[N+1]};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = sum[N:0];
                end
                x_next = {x_reg[N-2:0], 1'b0};
                y_next = {1'b0, y_reg[N-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.done = done_reg;
    assign result   = (op_reg == rcwt_pkg::OP_DIV) ? x_reg : acc_reg[N-1:0];

endmodule
